FILE: rtl/slf_pkg.sv
// Shared constants and types of the spring link force block.
package slf_pkg;

    localparam int COORD_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int REG_W   = 32;
    localparam int DIST_W  = 33;
    localparam int FORCE_W = 48;
    localparam int ADDR_W  = 3;

    localparam logic [REG_W-1:0]   MIN_DISTANCE_RST = 32'd1;
    localparam logic [DIST_W-1:0]  DIST_MAX         = '1;
    localparam logic [FORCE_W-1:0] FORCE_POS_MAX    = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] FORCE_NEG_MAX    = {1'b1, {(FORCE_W-1){1'b0}}};

    typedef enum logic [0:0] {
        REG_MIN_DISTANCE = 1'b0
    } reg_idx_t;

    typedef enum logic {
        CMD_MEASURE = 1'b0,
        CMD_FORCE   = 1'b1
    } cmd_t;

endpackage

FILE: rtl/slf_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module slf_sqrt #(
    parameter int IN_W  = 66,
    parameter int OUT_W = 33,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [IN_W-1:0]  radicand,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [OUT_W-1:0] root,
    output logic [TAG_W-1:0] out_tag
);

    logic [IN_W-1:0]  rem_q [OUT_W+1];
    logic [OUT_W-1:0] res_q [OUT_W+1];
    logic [TAG_W-1:0] tag_q [OUT_W+1];
    logic             vld_q [OUT_W+1];

    assign rem_q[0] = radicand;
    assign res_q[0] = '0;
    assign tag_q[0] = in_tag;
    assign vld_q[0] = in_valid;

    for (genvar s = 0; s < OUT_W; s++)
    begin : g_stage
        localparam int B = OUT_W - 1 - s;

        logic [IN_W:0]    trial;
        logic             take;
        logic [IN_W-1:0]  rem_next, rem_reg;
        logic [OUT_W-1:0] res_next, res_reg;
        logic [TAG_W-1:0] tag_reg;
        logic             vld_reg;

        // (2*res + 2^B) * 2^B against the remaining radicand
        always_comb
        begin
            trial    = ((IN_W+1)'(res_q[s]) << (B + 1)) + ((IN_W+1)'(1) << (2 * B));
            take     = trial <= {1'b0, rem_q[s]};
            rem_next = take ? rem_q[s] - trial[IN_W-1:0] : rem_q[s];
            res_next = take ? (res_q[s] | (OUT_W'(1) << B)) : res_q[s];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_q[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                res_reg <= res_next;
                tag_reg <= tag_q[s];
            end
        end

        assign rem_q[s+1] = rem_reg;
        assign res_q[s+1] = res_reg;
        assign tag_q[s+1] = tag_reg;
        assign vld_q[s+1] = vld_reg;
    end

    assign out_valid = vld_q[OUT_W];
    assign root      = res_q[OUT_W];
    assign out_tag   = tag_q[OUT_W];

endmodule

FILE: rtl/slf_div.sv
// Pipelined three-lane restoring divider with quotient overflow detect.
module slf_div
    import slf_pkg::*;
#(
    parameter int NUM_W = 130,
    parameter int DIV_W = 49,
    parameter int TAG_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [NUM_W-1:0]   num [3],
    input  logic [DIV_W-1:0]   divisor,
    input  logic [TAG_W-1:0]   in_tag,
    output logic               out_valid,
    output logic [FORCE_W-1:0] quot [3],
    output logic [2:0]         over,
    output logic [TAG_W-1:0]   out_tag
);

    localparam int RMW = DIV_W + 1;
    localparam int CW  = (NUM_W > DIV_W) ? NUM_W : DIV_W;

    logic [RMW-1:0]     rem_q  [FORCE_W+1][3];
    logic [FORCE_W-1:0] low_q  [FORCE_W+1][3];
    logic [FORCE_W-1:0] quo_q  [FORCE_W+1][3];
    logic [DIV_W-1:0]   dv_q   [FORCE_W+1];
    logic [2:0]         ovf_q  [FORCE_W+1];
    logic [TAG_W-1:0]   tag_q  [FORCE_W+1];
    logic               vld_q  [FORCE_W+1];

    // entry stage: quotient of FORCE_W bits fits only if num < divisor * 2^FORCE_W
    if (1)
    begin : g_entry
        logic [RMW-1:0]     rem_reg [3];
        logic [FORCE_W-1:0] low_reg [3];
        logic [2:0]         ovf_next, ovf_reg;
        logic [DIV_W-1:0]   dv_reg;
        logic [TAG_W-1:0]   tag_reg;
        logic               vld_reg;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                ovf_next[i] = CW'(num[i] >> FORCE_W) >= CW'(divisor);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= in_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= RMW'(num[i] >> FORCE_W);
                    low_reg[i] <= num[i][FORCE_W-1:0];
                end
                ovf_reg <= ovf_next;
                dv_reg  <= divisor;
                tag_reg <= in_tag;
            end
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            assign rem_q[0][i] = rem_reg[i];
            assign low_q[0][i] = low_reg[i];
            assign quo_q[0][i] = '0;
        end
        assign dv_q[0]  = dv_reg;
        assign ovf_q[0] = ovf_reg;
        assign tag_q[0] = tag_reg;
        assign vld_q[0] = vld_reg;
    end

    for (genvar s = 0; s < FORCE_W; s++)
    begin : g_stage
        localparam int J = FORCE_W - 1 - s;

        logic [RMW-1:0]     rem_next [3];
        logic [RMW-1:0]     rem_reg  [3];
        logic [FORCE_W-1:0] quo_next [3];
        logic [FORCE_W-1:0] quo_reg  [3];
        logic [FORCE_W-1:0] low_reg  [3];
        logic [DIV_W-1:0]   dv_reg;
        logic [2:0]         ovf_reg;
        logic [TAG_W-1:0]   tag_reg;
        logic               vld_reg;

        always_comb
        begin
            logic [RMW-1:0] sh;
            logic           ge;
            for (int i = 0; i < 3; i++)
            begin
                sh          = {rem_q[s][i][RMW-2:0], low_q[s][i][FORCE_W-1]};
                ge          = sh >= RMW'(dv_q[s]);
                rem_next[i] = ge ? sh - RMW'(dv_q[s]) : sh;
                quo_next[i] = ge ? (quo_q[s][i] | (FORCE_W'(1) << J)) : quo_q[s][i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_q[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= rem_next[i];
                    quo_reg[i] <= quo_next[i];
                    low_reg[i] <= low_q[s][i] << 1;
                end
                dv_reg  <= dv_q[s];
                ovf_reg <= ovf_q[s];
                tag_reg <= tag_q[s];
            end
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            assign rem_q[s+1][i] = rem_reg[i];
            assign quo_q[s+1][i] = quo_reg[i];
            assign low_q[s+1][i] = low_reg[i];
        end
        assign dv_q[s+1]  = dv_reg;
        assign ovf_q[s+1] = ovf_reg;
        assign tag_q[s+1] = tag_reg;
        assign vld_q[s+1] = vld_reg;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_out
        assign quot[i] = quo_q[FORCE_W][i];
    end
    assign over      = ovf_q[FORCE_W];
    assign out_tag   = tag_q[FORCE_W];
    assign out_valid = vld_q[FORCE_W];

endmodule

FILE: rtl/spring_link_force.sv
// Top level of the spring link force pipeline.
//
// Usage:
//  - Input stream (s_*): one word per spring link. s_tuser is the command
//    (0 measure, 1 force); s_tdata holds both endpoints and k, rest length.
//  - Output stream (m_*): one word per input word, in order. m_tdata holds
//    the distance and the three force increments for the second endpoint;
//    the first endpoint takes the negated increments.
//  - APB port: register 0 at byte address 0 is min_distance (Q16.16).
//    Write it only while the pipeline is empty.
// Pipeline from accept to m_tvalid: 4 front stages, one stage per root bit
// of the square root, 4 product stages A to D, 1 + 48 stages of the
// quotient divider, output register.
// Throughput: one word per cycle unless stalled; fully pipelined.
// Reset clears all valid bits and sets min_distance to 1.
// Stall: when m_tvalid is high and m_tready low the whole pipeline holds and
// s_tready drops; bubbles ahead of the output keep moving while the output
// register is empty.
module spring_link_force
    import slf_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int IN_TW  = ((6 * COORD_BITS + 2 * REG_W + 7) / 8) * 8,
    localparam int OUT_TW = ((DIST_W + 3 * FORCE_W + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // stiffness, rest_length (from bit 0 up)
    input  logic [IN_TW-1:0]  s_tdata,
    // command
    input  logic [0:0]        s_tuser,
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    // distance, force_x, force_y, force_z (from bit 0 up)
    output logic [OUT_TW-1:0] m_tdata,
    // too_close, saturated (from bit 0 up)
    output logic [1:0]        m_tuser,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready
);

    localparam int CB   = COORD_BITS;
    localparam int FB   = FRACTION_BITS;
    localparam int MW   = CB;                  // |p2 - p1| per axis
    localparam int SW   = 2 * CB + 2;          // sum of squares
    localparam int RW   = CB + 1;              // root
    localparam int EW   = (RW > DIST_W) ? RW : DIST_W;
    localparam int KW   = REG_W + EW;          // k * |l0 - d|
    localparam int NW   = KW + MW;             // numerator
    localparam int DVW  = RW + FB;             // d scaled by 2^FB
    localparam int STW  = 1 + 2 * REG_W + 3 * MW + 3;
    localparam int DTW  = DIST_W + 4 + 3;

    // global pipeline advance
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- configuration ----------------
    logic [REG_W-1:0] min_distance_reg;
    logic             cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = reg_idx_t'(paddr[ADDR_W-1:2]) == REG_MIN_DISTANCE;
    assign prdata  = cfg_hit ? min_distance_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg <= MIN_DISTANCE_RST;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            min_distance_reg <= pwdata;
        end
    end

    // ---------------- stage 0: axis differences ----------------
    logic [CB:0]      diff_next [3];
    logic [CB:0]      diff0_reg [3];
    logic [REG_W-1:0] k0_reg, l00_reg;
    cmd_t             cmd0_reg;
    logic             vld0_reg;

    always_comb
    begin
        logic [CB-1:0] fst, sec;
        for (int i = 0; i < 3; i++)
        begin
            fst          = s_tdata[i*CB +: CB];
            sec          = s_tdata[(3+i)*CB +: CB];
            diff_next[i] = {sec[CB-1], sec} - {fst[CB-1], fst};
        end
    end

    // ---------------- stage 1: sign and magnitude ----------------
    logic [MW-1:0]    mag_next [3];
    logic [MW-1:0]    mag1_reg [3];
    logic [2:0]       neg1_reg;
    logic [REG_W-1:0] k1_reg, l01_reg;
    cmd_t             cmd1_reg;
    logic             vld1_reg;

    always_comb
    begin
        logic [CB:0] a;
        for (int i = 0; i < 3; i++)
        begin
            a           = diff0_reg[i][CB] ? (~diff0_reg[i]) + 1'b1 : diff0_reg[i];
            mag_next[i] = a[MW-1:0];
        end
    end

    // ---------------- stage 2: squares, stage 3: sum ----------------
    logic [2*MW-1:0]  sq2_reg [3];
    logic [MW-1:0]    mag2_reg [3];
    logic [2:0]       neg2_reg;
    logic [REG_W-1:0] k2_reg, l02_reg;
    cmd_t             cmd2_reg;
    logic             vld2_reg;

    logic [SW-1:0]    sum3_reg;
    logic [MW-1:0]    mag3_reg [3];
    logic [2:0]       neg3_reg;
    logic [REG_W-1:0] k3_reg, l03_reg;
    cmd_t             cmd3_reg;
    logic             vld3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= s_tvalid;
            vld1_reg <= vld0_reg;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                diff0_reg[i] <= diff_next[i];
                mag1_reg[i]  <= mag_next[i];
                neg1_reg[i]  <= diff0_reg[i][CB];
                sq2_reg[i]   <= mag1_reg[i] * mag1_reg[i];
                mag2_reg[i]  <= mag1_reg[i];
                mag3_reg[i]  <= mag2_reg[i];
            end
            k0_reg   <= s_tdata[6*CB +: REG_W];
            l00_reg  <= s_tdata[6*CB+REG_W +: REG_W];
            cmd0_reg <= cmd_t'(s_tuser[0]);
            k1_reg   <= k0_reg;
            l01_reg  <= l00_reg;
            cmd1_reg <= cmd0_reg;
            neg2_reg <= neg1_reg;
            k2_reg   <= k1_reg;
            l02_reg  <= l01_reg;
            cmd2_reg <= cmd1_reg;
            sum3_reg <= SW'(sq2_reg[0]) + SW'(sq2_reg[1]) + SW'(sq2_reg[2]);
            neg3_reg <= neg2_reg;
            k3_reg   <= k2_reg;
            l03_reg  <= l02_reg;
            cmd3_reg <= cmd2_reg;
        end
    end

    // ---------------- square root ----------------
    logic             sq_vld;
    logic [RW-1:0]    sq_root;
    logic [STW-1:0]   sq_tag;
    logic             cmd_s;
    logic [REG_W-1:0] k_s, l0_s;
    logic [MW-1:0]    mag_s [3];
    logic [2:0]       neg_s;

    slf_sqrt #(
        .IN_W  (SW),
        .OUT_W (RW),
        .TAG_W (STW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld3_reg),
        .radicand  (sum3_reg),
        .in_tag    ({cmd3_reg, k3_reg, l03_reg, mag3_reg[2], mag3_reg[1], mag3_reg[0],
                     neg3_reg}),
        .out_valid (sq_vld),
        .root      (sq_root),
        .out_tag   (sq_tag)
    );

    assign {cmd_s, k_s, l0_s, mag_s[2], mag_s[1], mag_s[0], neg_s} = sq_tag;

    // ---------------- stage A: distance checks, |l0 - d| ----------------
    logic [EW-1:0]     d_e, l0_e;
    logic              dsat_next, close_next, dneg_next;
    logic [DIST_W-1:0] dist_next;

    assign d_e        = EW'(sq_root);
    assign l0_e       = EW'(l0_s);
    assign dsat_next  = d_e > EW'(DIST_MAX);
    assign dist_next  = dsat_next ? DIST_MAX : DIST_W'(d_e);
    assign close_next = (sq_root == '0) || (d_e < EW'(min_distance_reg));
    assign dneg_next  = d_e > l0_e;

    logic [EW-1:0]     dm_a_reg;
    logic [RW-1:0]     d_a_reg;
    logic [DIST_W-1:0] dist_a_reg;
    logic              dsat_a_reg, act_a_reg, too_a_reg, dneg_a_reg;
    logic [REG_W-1:0]  k_a_reg;
    logic [MW-1:0]     mag_a_reg [3];
    logic [2:0]        neg_a_reg;
    logic              vld_a_reg;

    // ---------------- stage B: k * |l0 - d| ----------------
    logic [KW-1:0]     kd_b_reg;
    logic [RW-1:0]     d_b_reg;
    logic [DIST_W-1:0] dist_b_reg;
    logic              dsat_b_reg, act_b_reg, too_b_reg, dneg_b_reg;
    logic [MW-1:0]     mag_b_reg [3];
    logic [2:0]        neg_b_reg;
    logic              vld_b_reg;

    // ---------------- stage C: partial products with |v_i| ----------------
    logic [REG_W+MW-1:0] plo_c_reg [3];
    logic [EW+MW-1:0]    phi_c_reg [3];
    logic [RW-1:0]       d_c_reg;
    logic [DIST_W-1:0]   dist_c_reg;
    logic                dsat_c_reg, act_c_reg, too_c_reg, dneg_c_reg;
    logic [2:0]          neg_c_reg;
    logic                vld_c_reg;

    // ---------------- stage D: numerators, scaled divisor ----------------
    logic [NW-1:0]       num_d_reg [3];
    logic [DVW-1:0]      dv_d_reg;
    logic [DIST_W-1:0]   dist_d_reg;
    logic                dsat_d_reg, act_d_reg, too_d_reg, dneg_d_reg;
    logic [2:0]          neg_d_reg;
    logic                vld_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= sq_vld;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // A
            dm_a_reg   <= dneg_next ? d_e - l0_e : l0_e - d_e;
            d_a_reg    <= sq_root;
            dist_a_reg <= dist_next;
            dsat_a_reg <= dsat_next;
            act_a_reg  <= (cmd_t'(cmd_s) == CMD_FORCE) && !close_next;
            too_a_reg  <= (cmd_t'(cmd_s) == CMD_FORCE) && close_next;
            dneg_a_reg <= dneg_next;
            k_a_reg    <= k_s;
            neg_a_reg  <= neg_s;
            // B
            kd_b_reg   <= k_a_reg * dm_a_reg;
            d_b_reg    <= d_a_reg;
            dist_b_reg <= dist_a_reg;
            dsat_b_reg <= dsat_a_reg;
            act_b_reg  <= act_a_reg;
            too_b_reg  <= too_a_reg;
            dneg_b_reg <= dneg_a_reg;
            neg_b_reg  <= neg_a_reg;
            // C
            d_c_reg    <= d_b_reg;
            dist_c_reg <= dist_b_reg;
            dsat_c_reg <= dsat_b_reg;
            act_c_reg  <= act_b_reg;
            too_c_reg  <= too_b_reg;
            dneg_c_reg <= dneg_b_reg;
            neg_c_reg  <= neg_b_reg;
            // D
            dv_d_reg   <= {d_c_reg, {FB{1'b0}}};
            dist_d_reg <= dist_c_reg;
            dsat_d_reg <= dsat_c_reg;
            act_d_reg  <= act_c_reg;
            too_d_reg  <= too_c_reg;
            dneg_d_reg <= dneg_c_reg;
            neg_d_reg  <= neg_c_reg;
            for (int i = 0; i < 3; i++)
            begin
                mag_a_reg[i] <= mag_s[i];
                mag_b_reg[i] <= mag_a_reg[i];
                plo_c_reg[i] <= kd_b_reg[REG_W-1:0] * mag_b_reg[i];
                phi_c_reg[i] <= kd_b_reg[KW-1:REG_W] * mag_b_reg[i];
                num_d_reg[i] <= NW'(plo_c_reg[i]) + (NW'(phi_c_reg[i]) << REG_W);
            end
        end
    end

    // ---------------- divider ----------------
    logic               dv_vld;
    logic [FORCE_W-1:0] dv_quot [3];
    logic [2:0]         dv_over;
    logic [DTW-1:0]     dv_tag;
    logic [DIST_W-1:0]  dist_q;
    logic               dsat_q, act_q, too_q, dneg_q;
    logic [2:0]         neg_q;

    slf_div #(
        .NUM_W (NW),
        .DIV_W (DVW),
        .TAG_W (DTW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_d_reg),
        .num       (num_d_reg),
        .divisor   (dv_d_reg),
        .in_tag    ({dist_d_reg, dsat_d_reg, act_d_reg, too_d_reg, dneg_d_reg, neg_d_reg}),
        .out_valid (dv_vld),
        .quot      (dv_quot),
        .over      (dv_over),
        .out_tag   (dv_tag)
    );

    assign {dist_q, dsat_q, act_q, too_q, dneg_q, neg_q} = dv_tag;

    // ---------------- output register: sign, clip ----------------
    logic [FORCE_W-1:0] force_next [3];
    logic [2:0]         clip;
    logic               sat_next;

    always_comb
    begin
        logic               fneg;
        logic [FORCE_W-1:0] lim, m;
        for (int i = 0; i < 3; i++)
        begin
            fneg          = dneg_q ^ neg_q[i];
            lim           = fneg ? FORCE_NEG_MAX : FORCE_POS_MAX;
            clip[i]       = dv_over[i] || (dv_quot[i] > lim);
            m             = clip[i] ? lim : dv_quot[i];
            force_next[i] = !act_q ? '0 : (fneg ? FORCE_W'(0) - m : m);
        end
        sat_next = dsat_q || (act_q && (clip != 3'b000));
    end

    logic               out_vld_reg;
    logic [DIST_W-1:0]  dist_o_reg;
    logic [FORCE_W-1:0] force_o_reg [3];
    logic               too_o_reg, sat_o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_o_reg <= dist_q;
            too_o_reg  <= too_q;
            sat_o_reg  <= sat_next;
            for (int i = 0; i < 3; i++)
            begin
                force_o_reg[i] <= force_next[i];
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_TW'({force_o_reg[2], force_o_reg[1], force_o_reg[0], dist_o_reg});
    assign m_tuser  = {sat_o_reg, too_o_reg};

endmodule
